// File: src/pht_pkg.sv
package pht_pkg;

   // Sizing
   localparam int PAGES      = 4096;
   localparam int COUNT_BITS = 16;
   localparam int ADDR_BITS  = $clog2(PAGES);
   localparam int SHIFT_BITS = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;
   localparam int EPOCH_BITS = 32;

   // Field widths fixed by the interface
   localparam int PAGE_FIELD_BITS  = 12;
   localparam int COUNT_FIELD_BITS = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 17;

   localparam logic [15:0] HOT_WRITE_LIMIT_RESET = 16'd4;
   localparam logic [16:0] HOT_READ_LIMIT_RESET  = 17'd8;
   localparam logic [15:0] COOLING_LIMIT_RESET   = 16'd18;

   typedef enum logic [0:0] {
      FUNC_SAMPLE  = 1'b0,
      FUNC_RELEASE = 1'b1
   } pht_func_type;

   typedef enum logic [1:0] {
      KIND_DRAM  = 2'd0,
      KIND_NVM   = 2'd1,
      KIND_WRITE = 2'd2
   } pht_kind_type;

   typedef enum logic [1:0] {
      REQ_NONE = 2'd0,
      REQ_HOT  = 2'd1,
      REQ_COLD = 2'd2
   } pht_request_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HOT_WRITE_LIMIT = 2'd0,
      CSR_HOT_READ_LIMIT  = 2'd1,
      CSR_COOLING_LIMIT   = 2'd2
   } pht_csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } pht_state_type;

   typedef struct packed {
      logic                       func;
      logic [PAGE_FIELD_BITS-1:0] page_index;
      logic [1:0]                 event_kind;
      logic                       mapped;
   } pht_req_type;

   typedef struct packed {
      logic [1:0]                  request;
      logic [PAGE_FIELD_BITS-1:0]  page_out;
      logic [COUNT_FIELD_BITS-1:0] decayed_count;
      logic [EPOCH_BITS-1:0]       epoch_out;
   } pht_rsp_type;

   // One page entry of the counter memory
   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [COUNT_BITS-1:0] wr_cnt;
      logic [COUNT_BITS-1:0] nvm_cnt;
      logic [COUNT_BITS-1:0] dram_cnt;
   } pht_row_type;

   localparam int ROW_BITS = $bits(pht_row_type);

   typedef struct packed {
      logic [15:0] hot_write_limit;
      logic [16:0] hot_read_limit;
      logic [15:0] cooling_limit;
   } pht_cfg_type;

   // Update stage results handed back to control
   typedef struct packed {
      logic                  wr_en;
      pht_row_type           row;
      logic [EPOCH_BITS-1:0] epoch_next;
      pht_rsp_type           rsp;
   } pht_upd_type;

endpackage

// File: src/pht_ram.sv
module pht_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pht_update.sv
module pht_update
   import pht_pkg::*;
(
   input  pht_req_type           item,
   input  pht_row_type           row,
   input  pht_cfg_type           cfg,
   input  logic [EPOCH_BITS-1:0] global_epoch,
   output pht_upd_type           upd
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic                  in_range;
   logic                  is_release;
   logic                  is_sample;
   logic [COUNT_BITS-1:0] old_cnt;
   logic [COUNT_BITS-1:0] inc_cnt;
   logic [COUNT_BITS-1:0] dram_i;
   logic [COUNT_BITS-1:0] nvm_i;
   logic [COUNT_BITS-1:0] wr_i;
   logic [COUNT_BITS:0]   reads;
   logic                  hot;
   logic [EPOCH_BITS-1:0] age;
   logic [COUNT_BITS-1:0] decayed;
   logic                  cool_step;

   assign in_range   = 32'(item.page_index) < 32'(PAGES);
   assign is_release = (item.func == FUNC_RELEASE);
   assign is_sample  = (item.func == FUNC_SAMPLE) && item.mapped &&
                       ((item.event_kind == KIND_DRAM) || (item.event_kind == KIND_NVM) ||
                        (item.event_kind == KIND_WRITE));

   always_comb begin
      case (item.event_kind)
         KIND_DRAM:  old_cnt = row.dram_cnt;
         KIND_NVM:   old_cnt = row.nvm_cnt;
         KIND_WRITE: old_cnt = row.wr_cnt;
         default:    old_cnt = '0;
      endcase
   end

   // saturating increment
   assign inc_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;

   assign dram_i = (item.event_kind == KIND_DRAM)  ? inc_cnt : row.dram_cnt;
   assign nvm_i  = (item.event_kind == KIND_NVM)   ? inc_cnt : row.nvm_cnt;
   assign wr_i   = (item.event_kind == KIND_WRITE) ? inc_cnt : row.wr_cnt;

   assign reads = (COUNT_BITS+1)'(dram_i) + (COUNT_BITS+1)'(nvm_i);
   assign hot   = (33'(wr_i) >= 33'(cfg.hot_write_limit)) ||
                  (33'(reads) >= 33'(cfg.hot_read_limit));

   // lazy decay: shift by epochs elapsed, zero once the age reaches the counter width
   assign age     = global_epoch - row.epoch;
   assign decayed = (age >= EPOCH_BITS'(COUNT_BITS)) ? '0 : (inc_cnt >> age[SHIFT_BITS-1:0]);

   assign cool_step = (33'(decayed) > 33'(cfg.cooling_limit));

   always_comb begin
      upd            = '0;
      upd.row        = row;
      upd.epoch_next = global_epoch;
      upd.rsp.request       = REQ_NONE;
      upd.rsp.page_out      = item.page_index;
      upd.rsp.decayed_count = '0;
      if (in_range && is_release) begin
         upd.wr_en       = 1'b1;
         upd.row.dram_cnt = '0;
         upd.row.nvm_cnt  = '0;
         upd.row.wr_cnt   = '0;
      end else if (in_range && is_sample) begin
         upd.wr_en        = 1'b1;
         upd.row.dram_cnt = (item.event_kind == KIND_DRAM)  ? decayed : row.dram_cnt;
         upd.row.nvm_cnt  = (item.event_kind == KIND_NVM)   ? decayed : row.nvm_cnt;
         upd.row.wr_cnt   = (item.event_kind == KIND_WRITE) ? decayed : row.wr_cnt;
         upd.row.epoch    = global_epoch;
         upd.rsp.request  = hot ? REQ_HOT : REQ_COLD;
         upd.rsp.decayed_count = COUNT_FIELD_BITS'(decayed);
         if (cool_step) begin
            upd.epoch_next = global_epoch + 1'b1;
         end
      end
      upd.rsp.epoch_out = upd.epoch_next;
   end

endmodule

// File: src/page_hotness_tracker.sv
// A command transferred in IDLE is captured in item_ff while the counter memory
// reads its page entry; in UPDATE the result is registered into rsp_data with
// rsp_valid high; the strobe lasts one cycle and the receiver cannot stall.
// A new command is taken only once the last is through: busy is held by the
// read-modify-write of the page entry in the single-port-write counter memory.
// Reset: synchronous; afterwards busy stays high while a clearing pass zeroes
// the PAGES (4096) counter memory entries. CSR writes are taken during it.
module page_hotness_tracker
   import pht_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // command channel
   input  logic                      start,
   output logic                      busy,
   input  pht_req_type               req_data,
   // result channel
   output logic                      rsp_valid,
   output pht_rsp_type               rsp_data,
   // CSR write port
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   pht_state_type         state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   pht_req_type           item_ff;
   logic [EPOCH_BITS-1:0] epoch_ff;
   pht_cfg_type           cfg_ff;
   logic                  rsp_valid_ff;
   pht_rsp_type           rsp_ff;

   logic                  accept;
   logic                  clr_last;
   pht_row_type           rd_row;
   logic [ROW_BITS-1:0]   rd_bits;
   pht_upd_type           upd;

   logic                  mem_wr_en;
   logic [ADDR_BITS-1:0]  mem_wr_addr;
   logic [ROW_BITS-1:0]   mem_wr_data;

   // A transfer happens only in IDLE, so the write-back of one command always
   // lands before the read of the next: no forwarding path is needed.
   assign accept   = start && !busy;
   assign clr_last = (clr_addr_ff == ADDR_BITS'(PAGES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  state_in = clr_last ? ST_IDLE : ST_CLEAR;
         ST_IDLE:   state_in = start ? ST_UPDATE : ST_IDLE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs of the control
   always_comb begin
      busy        = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_UPDATE: begin
            mem_wr_en   = upd.wr_en;
            mem_wr_addr = ADDR_BITS'(item_ff.page_index);
            mem_wr_data = upd.row;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= (state_ff == ST_UPDATE);
         if (state_ff == ST_UPDATE) begin
            epoch_ff <= upd.epoch_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_UPDATE) begin
         rsp_ff <= upd.rsp;
      end
   end

   // CSRs; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hot_write_limit <= HOT_WRITE_LIMIT_RESET;
         cfg_ff.hot_read_limit  <= HOT_READ_LIMIT_RESET;
         cfg_ff.cooling_limit   <= COOLING_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOT_WRITE_LIMIT: cfg_ff.hot_write_limit <= csr_wdata[15:0];
            CSR_HOT_READ_LIMIT:  cfg_ff.hot_read_limit  <= csr_wdata[16:0];
            CSR_COOLING_LIMIT:   cfg_ff.cooling_limit   <= csr_wdata[15:0];
            default:             cfg_ff <= cfg_ff;
         endcase
      end
   end

   // per-page counters and epoch, one row per page
   pht_ram #(
      .DEPTH (PAGES),
      .WIDTH (ROW_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(req_data.page_index)),
      .rd_data (rd_bits)
   );

   assign rd_row = rd_bits;

   pht_update u_update (
      .item         (item_ff),
      .row          (rd_row),
      .cfg          (cfg_ff),
      .global_epoch (epoch_ff),
      .upd          (upd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
